>>> src/rmm_pkg.sv
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types, field layout and helpers for the range min/max segment tree.
// ----------------------------------------------------------------------------
`default_nettype none

package rmm_pkg;

   localparam int unsigned LEAF_COUNT_DEF = 1024;

   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned VALUE_W = 30;

   // request tdata layout, lowest bit first
   localparam int unsigned LEFT_LSB  = 0;
   localparam int unsigned RIGHT_LSB = LEFT_LSB + INDEX_W;
   localparam int unsigned VALUE_LSB = RIGHT_LSB + INDEX_W;
   localparam int unsigned REQ_BITS  = VALUE_LSB + VALUE_W;
   localparam int unsigned REQ_W     = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int unsigned RSP_BITS = 2 * VALUE_W;
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [VALUE_W-1:0] MIN_IDENTITY = VALUE_W'(1000000000);
   localparam logic [VALUE_W-1:0] MAX_IDENTITY = '0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_BUILD = 2'd1,
      FUNC_QUERY = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BUILD_RD,
      ST_BUILD_WR,
      ST_QUERY,
      ST_QUERY_LAST,
      ST_RESULT
   } seq_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] max_val;
      logic [VALUE_W-1:0] min_val;
   } node_type;

   typedef struct packed {
      logic init;     // reset the accumulator to the identity pair
      logic take_a;   // read port a issued a node to fold next cycle
      logic take_b;   // read port b issued a node to fold next cycle
      logic load;     // move the accumulator into the response register
   } fold_ctrl_type;

   localparam node_type NODE_IDENTITY = '{max_val: MAX_IDENTITY, min_val: MIN_IDENTITY};

   function automatic node_type node_merge(input node_type a, input node_type b);
      node_type r;
      r.min_val = (a.min_val < b.min_val) ? a.min_val : b.min_val;
      r.max_val = (a.max_val > b.max_val) ? a.max_val : b.max_val;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/range_min_max_segment_tree.sv
// ----------------------------------------------------------------------------
// range_min_max_segment_tree
// Range minimum and maximum over LEAF_COUNT leaves kept as two segment trees.
// ----------------------------------------------------------------------------
// Node i of both trees (min and max) shares one memory word; leaf k is node
// LEAF_COUNT + k and node i has children 2i and 2i+1. The memory has one write
// port and two registered read ports. After reset a clearing pass writes the
// identity values (1000000000 for min, 0 for max) into all 2*LEAF_COUNT words,
// one a cycle, and req_tready stays low until that pass is done. A leaf
// write (tuser 0) writes its leaf word directly. A build (tuser 1) takes each
// inner node in turn as a read of both children then a merged write. A query
// (tuser 2) climbs one tree level per cycle with both read ports, and an
// empty range goes straight to the result; a query's last cycle stretches
// while the output register still holds an unaccepted response. Only queries
// give a response; one finished response is held in an output register so a
// new request transfer is taken while it waits. After the clearing pass, inner
// nodes change only on build.
// ----------------------------------------------------------------------------
`default_nettype none

module range_min_max_segment_tree #(
   parameter int unsigned LEAF_COUNT = rmm_pkg::LEAF_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [rmm_pkg::REQ_W-1:0]     req_tdata,   // left_index, right_index, leaf_value
   input  wire logic [rmm_pkg::FUNC_W-1:0]    req_tuser,   // func
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [rmm_pkg::RSP_W-1:0]          rsp_tdata    // range_min, range_max
);
   import rmm_pkg::*;

   localparam int unsigned NODE_W = $clog2(2 * LEAF_COUNT);

   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   node_type          wr_data;
   logic [NODE_W-1:0] rd_addr_a;
   logic [NODE_W-1:0] rd_addr_b;
   node_type          rd_data_a;
   node_type          rd_data_b;
   fold_ctrl_type     fold_ctrl;
   logic              out_free;

   rmm_node_ram #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   rmm_seq #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .fold_ctrl  (fold_ctrl),
      .out_free   (out_free)
   );

   rmm_fold u_fold (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (fold_ctrl),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> src/rmm_node_ram.sv
// ----------------------------------------------------------------------------
// rmm_node_ram
// Node store for both trees: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rmm_node_ram #(
   parameter int unsigned LEAF_COUNT = rmm_pkg::LEAF_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [$clog2(2*LEAF_COUNT)-1:0]    wr_addr,
   input  wire rmm_pkg::node_type                  wr_data,
   input  wire logic [$clog2(2*LEAF_COUNT)-1:0]    rd_addr_a,
   input  wire logic [$clog2(2*LEAF_COUNT)-1:0]    rd_addr_b,
   output rmm_pkg::node_type                       rd_data_a,
   output rmm_pkg::node_type                       rd_data_b
);
   import rmm_pkg::*;

   localparam int unsigned DEPTH = 2 * LEAF_COUNT;

   node_type mem [DEPTH];
   node_type rd_a_ff;
   node_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

>>> src/rmm_fold.sv
// ----------------------------------------------------------------------------
// rmm_fold
// Folds query nodes into a running min/max pair and holds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module rmm_fold (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rmm_pkg::fold_ctrl_type        ctrl,
   input  wire rmm_pkg::node_type             rd_data_a,
   input  wire rmm_pkg::node_type             rd_data_b,
   output logic                               out_free,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [rmm_pkg::RSP_W-1:0]          rsp_tdata   // range_min, range_max
);
   import rmm_pkg::*;

   logic     take_a_ff, take_a_in;
   logic     take_b_ff, take_b_in;
   node_type acc_ff, acc_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      take_a_in = ctrl.take_a;
      take_b_in = ctrl.take_b;

      acc_in = acc_ff;
      if (take_a_ff) begin
         acc_in = node_merge(acc_in, rd_data_a);
      end
      if (take_b_ff) begin
         acc_in = node_merge(acc_in, rd_data_b);
      end
      if (ctrl.init) begin
         acc_in = NODE_IDENTITY;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({acc_ff.max_val, acc_ff.min_val});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_a_ff    <= 1'b0;
         take_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         take_a_ff    <= take_a_in;
         take_b_ff    <= take_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/rmm_seq.sv
// ----------------------------------------------------------------------------
// rmm_seq
// Sequencer: clearing pass, leaf writes, bottom-up build and the query walk.
// ----------------------------------------------------------------------------
`default_nettype none

module rmm_seq #(
   parameter int unsigned LEAF_COUNT = rmm_pkg::LEAF_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [rmm_pkg::REQ_W-1:0]          req_tdata,
   input  wire logic [rmm_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                    wr_en,
   output logic [$clog2(2*LEAF_COUNT)-1:0]         wr_addr,
   output rmm_pkg::node_type                       wr_data,
   output logic [$clog2(2*LEAF_COUNT)-1:0]         rd_addr_a,
   output logic [$clog2(2*LEAF_COUNT)-1:0]         rd_addr_b,
   input  wire rmm_pkg::node_type                  rd_data_a,
   input  wire rmm_pkg::node_type                  rd_data_b,
   output rmm_pkg::fold_ctrl_type                  fold_ctrl,
   input  wire logic                               out_free
);
   import rmm_pkg::*;

   localparam int unsigned LEAF_W    = $clog2(LEAF_COUNT);
   localparam int unsigned NODE_W    = LEAF_W + 1;
   localparam int unsigned NODE_LAST = 2 * LEAF_COUNT - 1;

   seq_state_type state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [LEAF_W-1:0] build_ff, build_in;
   logic [NODE_W-1:0] node_a_ff, node_a_in;
   logic [NODE_W-1:0] node_b_ff, node_b_in;

   func_type           func;
   logic [INDEX_W-1:0] left_idx;
   logic [INDEX_W-1:0] right_idx;
   logic [VALUE_W-1:0] leaf_val;
   logic [VALUE_W-1:0] leaf_sat;
   logic               accept;
   logic               left_ok;
   logic               q_empty;
   logic [31:0]        hi_leaf;
   logic [NODE_W-1:0]  lo_node;
   logic [NODE_W-1:0]  hi_node;
   logic               clr_done;
   logic               walk_on;
   logic [NODE_W:0]    a_inc;
   logic [NODE_W-1:0]  b_dec;
   logic [NODE_W-1:0]  a_up;
   logic [NODE_W-1:0]  b_up;

   // request decode
   always_comb begin
      func      = func_type'(req_tuser);
      left_idx  = req_tdata[LEFT_LSB +: INDEX_W];
      right_idx = req_tdata[RIGHT_LSB +: INDEX_W];
      leaf_val  = req_tdata[VALUE_LSB +: VALUE_W];
      leaf_sat  = (leaf_val > MIN_IDENTITY) ? MIN_IDENTITY : leaf_val;
      accept    = req_tvalid && req_tready;
      left_ok   = 32'(left_idx) < 32'(LEAF_COUNT);
      // query end saturates to the last leaf
      hi_leaf   = (32'(right_idx) >= 32'(LEAF_COUNT)) ? 32'(LEAF_COUNT - 1) : 32'(right_idx);
      q_empty   = 32'(left_idx) > hi_leaf;
      lo_node   = NODE_W'(32'(LEAF_COUNT) + 32'(left_idx));
      hi_node   = NODE_W'(32'(LEAF_COUNT) + hi_leaf);
   end

   // one tree level per step: take the odd left and even right boundary nodes
   always_comb begin
      walk_on  = node_a_ff < node_b_ff;
      a_inc    = {1'b0, node_a_ff} + (NODE_W + 1)'(node_a_ff[0]);
      b_dec    = node_b_ff - NODE_W'(!node_b_ff[0]);
      a_up     = a_inc[NODE_W:1];
      b_up     = {1'b0, b_dec[NODE_W-1:1]};
      clr_done = clr_ff == NODE_W'(NODE_LAST);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (func)
                  FUNC_BUILD: state_in = ST_BUILD_RD;
                  FUNC_QUERY: state_in = q_empty ? ST_RESULT : ST_QUERY;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_BUILD_RD:   state_in = ST_BUILD_WR;
         ST_BUILD_WR:   state_in = (build_ff == LEAF_W'(1)) ? ST_IDLE : ST_BUILD_RD;
         ST_QUERY:      state_in = walk_on ? ST_QUERY : ST_QUERY_LAST;
         ST_QUERY_LAST: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = state_ff == ST_IDLE;
      wr_en      = 1'b0;
      wr_addr    = lo_node;
      wr_data    = '{max_val: leaf_sat, min_val: leaf_sat};
      rd_addr_a  = node_a_ff;
      rd_addr_b  = node_b_ff;
      fold_ctrl  = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = NODE_IDENTITY;
         end
         ST_IDLE: begin
            wr_en          = accept && (func == FUNC_WRITE) && left_ok;
            fold_ctrl.init = accept && (func == FUNC_QUERY);
         end
         ST_BUILD_RD: begin
            rd_addr_a = {build_ff, 1'b0};
            rd_addr_b = {build_ff, 1'b1};
         end
         ST_BUILD_WR: begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, build_ff};
            wr_data = node_merge(rd_data_a, rd_data_b);
         end
         ST_QUERY: begin
            // once the bounds meet, port a fetches the shared node
            fold_ctrl.take_a = walk_on ? node_a_ff[0] : (node_a_ff == node_b_ff);
            fold_ctrl.take_b = walk_on && !node_b_ff[0];
         end
         ST_RESULT: begin
            fold_ctrl.load = out_free;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      clr_in    = (state_ff == ST_CLEAR) ? clr_ff + NODE_W'(1) : clr_ff;
      build_in  = build_ff;
      node_a_in = node_a_ff;
      node_b_in = node_b_ff;
      if (state_ff == ST_IDLE && accept) begin
         build_in  = LEAF_W'(LEAF_COUNT - 1);
         node_a_in = lo_node;
         node_b_in = hi_node;
      end else if (state_ff == ST_BUILD_WR) begin
         build_in = build_ff - LEAF_W'(1);
      end else if (state_ff == ST_QUERY && walk_on) begin
         node_a_in = a_up;
         node_b_in = b_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      build_ff  <= build_in;
      node_a_ff <= node_a_in;
      node_b_ff <= node_b_in;
   end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for range_min_max_segment_tree: leaf writes, builds,
// range queries and unused codes go in over req_, a shadow copy of both trees
// predicts every query, and each rsp_ transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

   import rmm_pkg::*;

   localparam int unsigned LEAF_COUNT     = LEAF_COUNT_DEF;
   localparam int unsigned NODE_COUNT     = 2 * LEAF_COUNT;
   localparam int unsigned RSP_MIN_LSB    = 0;
   localparam int unsigned RSP_MAX_LSB    = VALUE_W;
   localparam int unsigned RANDOM_OPS     = 480;
   localparam int unsigned DRAIN_CYCLES   = 2 * NODE_COUNT + 64;
   localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] left_idx;
      logic [INDEX_W-1:0] right_idx;
      logic [VALUE_W-1:0] value;
   } tree_op_type;

   typedef struct {
      logic [VALUE_W-1:0] min_val;
      logic [VALUE_W-1:0] max_val;
   } range_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;   // left_index, right_index, leaf_value
   logic [FUNC_W-1:0] req_tuser  = '0;   // func
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;         // range_min, range_max

   // shadow trees, same node numbering as the block
   logic [VALUE_W-1:0] min_tree [NODE_COUNT];
   logic [VALUE_W-1:0] max_tree [NODE_COUNT];

   tree_op_type      tree_op_q[$];
   range_result_type range_result_q[$];

   int unsigned ops_total    = 0;
   int unsigned ops_accepted = 0;
   int unsigned fail_count   = 0;
   bit          req_taken    = 1'b0;

   int unsigned burst_left = 0;
   int unsigned send_gap   = 0;
   int unsigned ready_count = 0;
   int unsigned ready_mode  = 0;
   logic [31:0] ready_bits  = '0;

   range_min_max_segment_tree #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic push_op(input logic [FUNC_W-1:0] func, input int unsigned left_idx,
                          input int unsigned right_idx, input logic [31:0] value);
      tree_op_type op;
      op.func      = func;
      op.left_idx  = left_idx[INDEX_W-1:0];
      op.right_idx = right_idx[INDEX_W-1:0];
      op.value     = value[VALUE_W-1:0];
      tree_op_q.insert(tree_op_q.size(), op);
      ops_total++;
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(negedge clock) begin : driver
      tree_op_type      op;
      logic [REQ_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (tree_op_q.size() != 0) begin
            op = tree_op_q.pop_front();
            word = '0;
            word[LEFT_LSB +: INDEX_W]  = op.left_idx;
            word[RIGHT_LSB +: INDEX_W] = op.right_idx;
            word[VALUE_LSB +: VALUE_W] = op.value;
            req_tdata  <= word;
            req_tuser  <= op.func;
            req_tvalid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               send_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 4);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: always ready, random, or mostly stalled, switching now and then
   always @(negedge clock) begin : receiver
      if (ready_count == 0) begin
         ready_count = $urandom_range(16, 96);
         ready_mode  = $urandom_range(0, 2);
         ready_bits  = $urandom;
      end else begin
         ready_count--;
         ready_bits = {ready_bits[0], ready_bits[31:1]};
      end
      case (ready_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ready_bits[0];
         end
         default: begin
            rsp_tready <= &ready_bits[1:0];
         end
      endcase
   end

   always @(posedge clock) begin : monitor
      range_result_type   want;
      logic [VALUE_W-1:0] got_min, got_max, leaf_val;
      int unsigned        lo_idx, hi_idx, node_a, node_b;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_min = rsp_tdata[RSP_MIN_LSB +: VALUE_W];
            got_max = rsp_tdata[RSP_MAX_LSB +: VALUE_W];
            if (range_result_q.size() == 0) begin
               $error("response with no query pending: range_min %0d range_max %0d",
                      got_min, got_max);
               fail_count++;
            end else begin
               want = range_result_q.pop_front();
               if (got_min !== want.min_val) begin
                  $error("range_min: expected %0d, got %0d", want.min_val, got_min);
                  fail_count++;
               end
               if (got_max !== want.max_val) begin
                  $error("range_max: expected %0d, got %0d", want.max_val, got_max);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            ops_accepted++;
            lo_idx   = req_tdata[LEFT_LSB +: INDEX_W];
            hi_idx   = req_tdata[RIGHT_LSB +: INDEX_W];
            leaf_val = req_tdata[VALUE_LSB +: VALUE_W];
            case (req_tuser)
               FUNC_WRITE: begin
                  if (leaf_val > MIN_IDENTITY) begin
                     leaf_val = MIN_IDENTITY;
                  end
                  min_tree[LEAF_COUNT + lo_idx] = leaf_val;
                  max_tree[LEAF_COUNT + lo_idx] = leaf_val;
               end
               FUNC_BUILD: begin
                  for (int k = LEAF_COUNT - 1; k > 0; k--) begin
                     min_tree[k] = (min_tree[2*k] < min_tree[2*k+1]) ? min_tree[2*k]
                                                                      : min_tree[2*k+1];
                     max_tree[k] = (max_tree[2*k] > max_tree[2*k+1]) ? max_tree[2*k]
                                                                      : max_tree[2*k+1];
                  end
               end
               FUNC_QUERY: begin
                  want.min_val = MIN_IDENTITY;
                  want.max_val = MAX_IDENTITY;
                  if (hi_idx >= LEAF_COUNT) begin
                     hi_idx = LEAF_COUNT - 1;
                  end
                  if (lo_idx <= hi_idx) begin
                     node_a = lo_idx + LEAF_COUNT;
                     node_b = hi_idx + LEAF_COUNT;
                     // climb one level per pass, folding boundary nodes inside the range
                     while (node_a < node_b) begin
                        if (node_a[0]) begin
                           if (min_tree[node_a] < want.min_val) want.min_val = min_tree[node_a];
                           if (max_tree[node_a] > want.max_val) want.max_val = max_tree[node_a];
                           node_a++;
                        end
                        if (!node_b[0]) begin
                           if (min_tree[node_b] < want.min_val) want.min_val = min_tree[node_b];
                           if (max_tree[node_b] > want.max_val) want.max_val = max_tree[node_b];
                           node_b--;
                        end
                        node_a = node_a >> 1;
                        node_b = node_b >> 1;
                     end
                     if (node_a == node_b) begin
                        if (min_tree[node_a] < want.min_val) want.min_val = min_tree[node_a];
                        if (max_tree[node_a] > want.max_val) want.max_val = max_tree[node_a];
                     end
                  end
                  range_result_q.insert(range_result_q.size(), want);
               end
               default: begin
                  // unused code, the block drops it
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned ops_left, write_count, query_count, hot_base, lo, hi, swap;
      logic [31:0] value;

      for (int i = 0; i < NODE_COUNT; i++) begin
         min_tree[i] = MIN_IDENTITY;
         max_tree[i] = MAX_IDENTITY;
      end

      // directed: identity tree, extreme values, stale inner nodes, build, edges
      push_op(FUNC_QUERY, 0, 1023, 0);
      push_op(FUNC_WRITE, 0, 0, 0);
      push_op(FUNC_WRITE, 1023, 1023, 1000000000);
      push_op(FUNC_WRITE, 5, 0, 32'h3FFF_FFFF);
      push_op(FUNC_WRITE, 6, 0, 1000000001);
      push_op(FUNC_WRITE, 512, 0, 32'h2AAA_AAAA);
      push_op(FUNC_WRITE, 513, 0, 32'h1555_5555);
      push_op(FUNC_QUERY, 0, 1023, 0);
      push_op(FUNC_QUERY, 5, 5, 0);
      push_op(FUNC_UNUSED, 1023, 1023, 32'h3FFF_FFFF);
      push_op(FUNC_BUILD, 0, 0, 0);
      push_op(FUNC_QUERY, 0, 1023, 0);
      push_op(FUNC_QUERY, 0, 0, 0);
      push_op(FUNC_QUERY, 1023, 1023, 0);
      push_op(FUNC_QUERY, 512, 513, 0);
      push_op(FUNC_QUERY, 600, 100, 0);
      push_op(FUNC_QUERY, 1, 1022, 0);
      push_op(FUNC_QUERY, 6, 6, 0);
      push_op(FUNC_WRITE, 3, 0, 7);
      push_op(FUNC_QUERY, 0, 7, 0);
      push_op(FUNC_BUILD, 0, 0, 0);
      push_op(FUNC_QUERY, 0, 7, 0);

      // random rounds: writes, usually a build, then a batch of queries
      ops_left = RANDOM_OPS;
      while (ops_left > 0) begin
         hot_base    = $urandom_range(0, LEAF_COUNT - 32);
         write_count = $urandom_range(4, 28);
         for (int i = 0; i < write_count; i++) begin
            lo = ($urandom_range(0, 3) == 0) ? hot_base + $urandom_range(0, 31)
                                             : $urandom_range(0, LEAF_COUNT - 1);
            case ($urandom_range(0, 9))
               0: value = $urandom;                        // may saturate
               1: value = $urandom_range(0, 15);
               2: value = 1000000000;
               default: value = $urandom_range(0, 1000000000);
            endcase
            push_op(FUNC_WRITE, lo, $urandom_range(0, LEAF_COUNT - 1), value);
            if ($urandom_range(0, 15) == 0) begin
               push_op(FUNC_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom);
            end else begin
               ops_left = (ops_left > 0) ? ops_left - 1 : 0;
            end
         end
         if ($urandom_range(0, 4) != 0) begin
            push_op(FUNC_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
            ops_left = (ops_left > 0) ? ops_left - 1 : 0;
         end
         query_count = $urandom_range(4, 16);
         for (int i = 0; i < query_count; i++) begin
            lo = $urandom_range(0, LEAF_COUNT - 1);
            hi = $urandom_range(0, LEAF_COUNT - 1);
            case ($urandom_range(0, 6))
               0: begin
                  // unordered pair, about half come out empty
               end
               1: begin
                  if (lo > hi) begin
                     swap = lo;
                     lo   = hi;
                     hi   = swap;
                  end
               end
               2: begin
                  hi = lo + $urandom_range(0, 7);
                  if (hi >= LEAF_COUNT) hi = LEAF_COUNT - 1;
               end
               3: begin
                  hi = lo;
               end
               4: begin
                  if ($urandom_range(0, 1) == 0) lo = 0;
                  else hi = LEAF_COUNT - 1;
                  if (lo > hi) lo = hi;
               end
               5: begin
                  lo = hot_base + $urandom_range(0, 15);
                  hi = hot_base + $urandom_range(16, 31);
               end
               default: begin
                  if (lo == hi) lo = (lo == 0) ? 1 : lo - 1;
                  if (lo < hi) begin
                     swap = lo;
                     lo   = hi;
                     hi   = swap;
                  end
               end
            endcase
            push_op(FUNC_QUERY, lo, hi, $urandom);
            ops_left = (ops_left > 0) ? ops_left - 1 : 0;
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (ops_accepted != ops_total || range_result_q.size() != 0) begin
         @(negedge clock);
      end
      // a trailing build gives no response, let it finish
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("[range_min_max_segment_tree] OK");
      end else begin
         $display("[range_min_max_segment_tree] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("[range_min_max_segment_tree] ERROR");
      $finish;
   end

endmodule
